// ----- sv/asc_pkg.sv -----
// Shared constants, configuration and pipeline item types for the size-class engine.
`timescale 1ns / 1ps

package asc_pkg;

    // Page, line, chunk and word geometry
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_ORDER  = $clog2(PAGE_BYTES);
    localparam int LINE_SIZE   = 64;
    localparam int LINE_ORDER  = 6;
    localparam int CHUNK_ORDER = 5;
    localparam int WORD_ORDER  = 3;

    // Block size register width and derived divider geometry
    localparam int BLK_W     = 31;
    localparam int DIV_STEPS = BLK_W - LINE_ORDER;
    localparam int LINE_W    = 40;
    localparam int DVS_W     = LINE_W - LINE_ORDER;
    localparam int BPAD_W    = PAGE_ORDER;

    // Layout status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_NOFIT    = 2'd2,
        ST_PAD      = 2'd3
    } t_status;

    // Configuration registers as the datapath sees them
    typedef struct packed {
        logic [2:0]       uo;
        logic [6:0]       ub;
        logic [3:0]       sx;
        logic [5:0]       hb;
        logic [BLK_W-1:0] bs;
    } t_cfg;

    // Item carried down the pipeline; each stage fills its own fields
    typedef struct packed {
        logic                 op;
        logic [15:0]          idx;
        logic [31:0]          x;
        logic [31:0]          len1;
        logic [15:0]          cls;
        logic [31:0]          len0;
        logic [38:0]          data;
        logic [5:0]           pad;
        logic [31:0]          chunks;
        logic [31:0]          qw;
        logic [BPAD_W-1:0]    tw;
        logic [26:0]          bchunks;
        logic [DVS_W-1:0]     dvs;
        logic [DIV_STEPS-1:0] quo;
        logic [DIV_STEPS-1:0] rem;
        logic [BPAD_W-1:0]    prod;
    } t_item;

    // Result item as delivered
    typedef struct packed {
        logic [15:0]       class_out;
        logic [31:0]       class_length;
        logic [31:0]       line_chunks;
        logic [5:0]        line_pad;
        logic [31:0]       line_qwords;
        logic [26:0]       block_chunks;
        logic [26:0]       lines_per_block;
        logic [BPAD_W-1:0] block_pad;
        t_status           status;
    } t_result;

endpackage

// ----- sv/asc_len.sv -----
// Entry stage: class index to class length, and choice of the size to classify.
`timescale 1ns / 1ps

module asc_len (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  asc_pkg::t_cfg  i_cfg,
    input  logic           i_vld,
    output logic           o_rdy,
    input  logic           i_op,
    input  logic [31:0]    i_size,
    input  logic [15:0]    i_idx,
    output logic           o_vld,
    input  logic           i_rdy,
    output asc_pkg::t_item o_item
);

    logic           r_vld;
    asc_pkg::t_item r_item;
    asc_pkg::t_item n_item;

    logic [16:0] w_a;
    logic        w_big;
    logic [16:0] w_hi;
    logic [17:0] w_r;
    logic [17:0] w_rs;
    logic [15:0] w_m;
    logic [63:0] w_p1;
    logic [63:0] w_p2;
    logic [63:0] w_bytes;
    logic [63:0] w_diff;
    logic [31:0] w_len;

    // Rebuild the byte size of the class, then strip the header and scale to units
    always_comb begin
        w_a     = {1'b0, i_idx} + 17'd1;
        w_big   = w_a > (17'd1 << i_cfg.sx);
        w_hi    = w_a >> i_cfg.sx;
        w_r     = 18'(w_hi) + 18'(asc_pkg::LINE_ORDER - 1) + 18'(i_cfg.sx);
        w_rs    = 18'(w_hi) + 18'(asc_pkg::LINE_ORDER - 1);
        w_m     = w_a[15:0] & ((16'd1 << i_cfg.sx) - 16'd1);
        w_p1    = (w_r < 18'd64) ? (64'd1 << w_r[5:0]) : '0;
        w_p2    = (w_rs < 18'd64) ? (64'(w_m) << w_rs[5:0]) : '0;
        w_bytes = w_big ? (w_p1 + w_p2) : (64'(w_a) << asc_pkg::LINE_ORDER);
        w_diff  = w_bytes - 64'(i_cfg.hb);
        w_len   = 32'(w_diff >> i_cfg.uo);

        n_item      = '0;
        n_item.op   = i_op;
        n_item.idx  = i_idx;
        n_item.len1 = w_len;
        n_item.x    = i_op ? w_len : i_size;
    end

    assign o_rdy  = !r_vld || i_rdy;
    assign o_vld  = r_vld;
    assign o_item = r_item;

    // Advance valid when the stage is free or drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- sv/asc_cls.sv -----
// Four-stage size to class mapper: sum, leading one, step select, length.
`timescale 1ns / 1ps

module asc_cls (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  asc_pkg::t_cfg  i_cfg,
    input  logic           i_vld,
    output logic           o_rdy,
    input  asc_pkg::t_item i_item,
    output logic           o_vld,
    input  logic           i_rdy,
    output asc_pkg::t_item o_item
);

    typedef struct packed {
        asc_pkg::t_item it;
        logic           c1;
        logic           c2;
        logic [39:0]    b2;
        logic [39:0]    bm1;
        logic [5:0]     r;
        logic [15:0]    a;
        logic [40:0]    up;
    } t_cst;

    logic [3:0] r_vld;
    logic [3:0] adv;
    t_cst       r_st [4];
    t_cst       n_st [4];

    logic [4:0] w_rmin;

    // Position of the highest set bit
    function automatic logic [5:0] f_msb(input logic [39:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 1; i < 40; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    assign w_rmin = 5'(asc_pkg::LINE_ORDER) + 5'(i_cfg.sx);

    // Stage 0: scale to bytes, add header, range tests
    always_comb begin
        logic [38:0] b;
        logic [6:0]  lim;
        b            = 39'(i_item.x) << i_cfg.uo;
        lim          = 7'(asc_pkg::LINE_SIZE) - {1'b0, i_cfg.hb};
        n_st[0]      = '0;
        n_st[0].it   = i_item;
        n_st[0].c1   = b > 39'(lim);
        n_st[0].b2   = 40'(b) + 40'(i_cfg.hb);
        n_st[0].c2   = n_st[0].b2 > (40'd1 << w_rmin);
        n_st[0].bm1  = n_st[0].b2 - 40'd1;
    end

    // Stage 1: leading one of bytes minus one
    always_comb begin
        n_st[1]   = r_st[0];
        n_st[1].r = f_msb(r_st[0].bm1);
    end

    // Stage 2: class index and rounded byte size
    always_comb begin
        logic [5:0]  k;
        logic [39:0] shr;
        logic [15:0] frac;
        logic [5:0]  rr;
        logic [15:0] hi;
        logic [40:0] qm1;
        k       = r_st[1].r - 6'(i_cfg.sx);
        shr     = r_st[1].bm1 >> k;
        frac    = shr[15:0] & ((16'd1 << i_cfg.sx) - 16'd1);
        rr      = r_st[1].r - 6'(w_rmin) + 6'd1;
        hi      = 16'(22'(rr) << i_cfg.sx);
        n_st[2] = r_st[1];
        if (r_st[1].c2) begin
            qm1       = (41'd1 << k) - 41'd1;
            n_st[2].a = hi + frac;
        end else begin
            qm1       = 41'(asc_pkg::LINE_SIZE - 1);
            n_st[2].a = r_st[1].bm1[asc_pkg::LINE_ORDER +: 16];
        end
        n_st[2].up = (41'(r_st[1].b2) + qm1) & ~qm1;
        if (!r_st[1].c1) begin
            n_st[2].a = '0;
        end
    end

    // Stage 3: class length in units
    always_comb begin
        logic [40:0] hbs;
        logic [6:0]  rest;
        hbs     = 41'(i_cfg.hb >> i_cfg.uo);
        rest    = 7'(asc_pkg::LINE_SIZE) - {1'b0, i_cfg.hb};
        n_st[3] = r_st[2];
        n_st[3].it.cls = r_st[2].a;
        if (r_st[2].c1) begin
            n_st[3].it.len0 = 32'((r_st[2].up >> i_cfg.uo) - hbs);
        end else begin
            n_st[3].it.len0 = 32'(rest >> i_cfg.uo);
        end
    end

    // Per-stage advance so bubbles close up under a stall
    assign adv[3] = !r_vld[3] || i_rdy;
    assign adv[2] = !r_vld[2] || adv[3];
    assign adv[1] = !r_vld[1] || adv[2];
    assign adv[0] = !r_vld[0] || adv[1];

    assign o_rdy  = adv[0];
    assign o_vld  = r_vld[3];
    assign o_item = r_st[3].it;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_vld;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_vld)    r_st[0] <= n_st[0];
        if (adv[1] && r_vld[0]) r_st[1] <= n_st[1];
        if (adv[2] && r_vld[1]) r_st[2] <= n_st[2];
        if (adv[3] && r_vld[2]) r_st[3] <= n_st[3];
    end

endmodule

// ----- sv/asc_prep.sv -----
// Two-stage line layout: data bytes, then pad, chunks, words and divisor.
`timescale 1ns / 1ps

module asc_prep (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  asc_pkg::t_cfg  i_cfg,
    input  logic           i_vld,
    output logic           o_rdy,
    input  asc_pkg::t_item i_item,
    output logic           o_vld,
    input  logic           i_rdy,
    output asc_pkg::t_item o_item
);

    logic [1:0]     r_vld;
    logic [1:0]     adv;
    asc_pkg::t_item r_it [2];
    asc_pkg::t_item n_it [2];

    // Stage 0: data bytes of the line
    always_comb begin
        n_it[0]      = i_item;
        n_it[0].data = 39'(i_item.len1) * 39'(i_cfg.ub);
    end

    // Stage 1: line bytes, pad to the cache line, derived counts
    always_comb begin
        logic [39:0] line;
        logic [39:0] stride;
        logic [40:0] chr;
        logic [39:0] dp;
        logic [5:0]  pad;
        logic [asc_pkg::BLK_W-1:0] blk;
        line   = 40'(r_it[0].data) + 40'(i_cfg.hb);
        pad    = 6'd0 - line[5:0];
        stride = line + 40'(pad);
        chr    = 41'(line) + 41'((1 << asc_pkg::CHUNK_ORDER) - 1);
        dp     = 40'(r_it[0].data) + 40'(pad);
        blk    = {i_cfg.bs[asc_pkg::BLK_W-1:asc_pkg::PAGE_ORDER],
                  asc_pkg::PAGE_ORDER'(0)};
        n_it[1]         = r_it[0];
        n_it[1].pad     = pad;
        n_it[1].chunks  = chr[asc_pkg::CHUNK_ORDER +: 32];
        n_it[1].qw      = dp[asc_pkg::WORD_ORDER +: 32];
        n_it[1].tw      = asc_pkg::BPAD_W'(i_cfg.hb)
                        + {dp[asc_pkg::BPAD_W-1:asc_pkg::WORD_ORDER],
                           asc_pkg::WORD_ORDER'(0)};
        n_it[1].bchunks = 27'(blk >> asc_pkg::CHUNK_ORDER);
        n_it[1].dvs     = stride[asc_pkg::LINE_W-1:asc_pkg::LINE_ORDER];
        n_it[1].quo     = '0;
        n_it[1].rem     = '0;
    end

    assign adv[1] = !r_vld[1] || i_rdy;
    assign adv[0] = !r_vld[0] || adv[1];

    assign o_rdy  = adv[0];
    assign o_vld  = r_vld[1];
    assign o_item = r_it[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_vld;
            if (adv[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_vld)    r_it[0] <= n_it[0];
        if (adv[1] && r_vld[0]) r_it[1] <= n_it[1];
    end

endmodule

// ----- sv/asc_div.sv -----
// Pipelined restoring divider: block lines over line stride, one quotient bit a stage.
`timescale 1ns / 1ps

module asc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  asc_pkg::t_cfg  i_cfg,
    input  logic           i_vld,
    output logic           o_rdy,
    input  asc_pkg::t_item i_item,
    output logic           o_vld,
    input  logic           i_rdy,
    output asc_pkg::t_item o_item
);

    localparam int N = asc_pkg::DIV_STEPS;

    logic [N-1:0]   r_vld;
    logic [N-1:0]   adv;
    asc_pkg::t_item r_it [N];
    asc_pkg::t_item n_it [N];
    logic [N:0]     w_vld;
    asc_pkg::t_item w_it [N+1];
    logic [N-1:0]   w_num;

    // Dividend: page-rounded block size in cache lines
    assign w_num = {i_cfg.bs[asc_pkg::BLK_W-1:asc_pkg::PAGE_ORDER],
                    (asc_pkg::PAGE_ORDER - asc_pkg::LINE_ORDER)'(0)};

    assign w_vld[0] = i_vld;
    assign w_it[0]  = i_item;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [N:0] rsh;
        logic       ge;

        assign w_vld[k+1] = r_vld[k];
        assign w_it[k+1]  = r_it[k];

        // Shift in the next dividend bit, subtract where it fits
        always_comb begin
            rsh     = {w_it[k].rem, w_num[N-1-k]};
            ge      = asc_pkg::DVS_W'(rsh) >= w_it[k].dvs;
            n_it[k] = w_it[k];
            n_it[k].rem = ge ? N'(rsh - (N+1)'(w_it[k].dvs)) : rsh[N-1:0];
            n_it[k].quo = {w_it[k].quo[N-2:0], ge};
        end

        if (k == N - 1) begin : g_last
            assign adv[k] = !r_vld[k] || i_rdy;
        end else begin : g_mid
            assign adv[k] = !r_vld[k] || adv[k+1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (adv[k]) begin
                r_vld[k] <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[k] && w_vld[k]) begin
                r_it[k] <= n_it[k];
            end
        end
    end

    assign o_rdy  = adv[0];
    assign o_vld  = w_vld[N];
    assign o_item = w_it[N];

endmodule

// ----- sv/asc_fin.sv -----
// Final stages: block pad, layout checks and the result register.
`timescale 1ns / 1ps

module asc_fin (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  asc_pkg::t_item   i_item,
    output logic             o_vld,
    input  logic             i_rdy,
    output asc_pkg::t_result o_res
);

    logic [1:0]       r_vld;
    logic [1:0]       adv;
    asc_pkg::t_item   r_it;
    asc_pkg::t_item   n_it;
    asc_pkg::t_result r_res;
    asc_pkg::t_result n_res;

    // Stage 0: settle lines per block, low bits of the lines' total
    always_comb begin
        logic [2*asc_pkg::BPAD_W-1:0] pw;
        n_it = i_item;
        if (i_item.dvs == '0) begin
            n_it.quo = '0;
        end
        pw        = n_it.tw * n_it.quo[asc_pkg::BPAD_W-1:0];
        n_it.prod = pw[asc_pkg::BPAD_W-1:0];
    end

    // Stage 1: pad to the page, status, pick fields by op
    always_comb begin
        logic [asc_pkg::BPAD_W-1:0] bpad;
        logic                       padf;
        bpad  = asc_pkg::BPAD_W'(0) - r_it.prod;
        padf  = asc_pkg::BLK_W'(bpad) > {r_it.rem, asc_pkg::LINE_ORDER'(0)};
        n_res = '0;
        if (r_it.op) begin
            n_res.class_out       = r_it.idx;
            n_res.class_length    = r_it.len1;
            n_res.line_chunks     = r_it.chunks;
            n_res.line_pad        = r_it.pad;
            n_res.line_qwords     = r_it.qw;
            n_res.block_chunks    = r_it.bchunks;
            n_res.lines_per_block = 27'(r_it.quo);
            n_res.block_pad       = bpad;
            if (r_it.cls != r_it.idx) begin
                n_res.status = asc_pkg::ST_MISMATCH;
            end else if (r_it.quo == '0) begin
                n_res.status = asc_pkg::ST_NOFIT;
            end else if (padf) begin
                n_res.status = asc_pkg::ST_PAD;
            end else begin
                n_res.status = asc_pkg::ST_OK;
            end
        end else begin
            n_res.class_out    = r_it.cls;
            n_res.class_length = r_it.len0;
            n_res.status       = asc_pkg::ST_OK;
        end
    end

    assign adv[1] = !r_vld[1] || i_rdy;
    assign adv[0] = !r_vld[0] || adv[1];

    assign o_rdy = adv[0];
    assign o_vld = r_vld[1];
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_vld;
            if (adv[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_vld)    r_it  <= n_it;
        if (adv[1] && r_vld[0]) r_res <= n_res;
    end

endmodule

// ----- sv/alloc_size_class_shape_top.sv -----
// Top level of the slab allocator size-class engine.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: request_size, class_index; tuser: op
//  m_axis    out  m_axis_tvalid/tready      tdata: class and layout fields, status
//  apb       in   psel/penable, pready = 1  five registers at 4*i, read as 32-bit words
//
//  One item per cycle sustained while the result channel is not stalled.
//  Lines per block come from the 25-stage restoring divider.
//  Reset is synchronous: it empties every stage and loads the register reset values.
//  A stalled result holds in the output register; earlier stages keep filling until full.
`timescale 1ns / 1ps

module alloc_size_class_shape_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // request_size[31:0], class_index[47:32]
    input  logic [0:0]   s_axis_tuser,   // op[0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // class_out[15:0], class_length[47:16],
                                         // line_chunks[79:48], line_pad[85:80],
                                         // line_qwords[117:86], block_chunks[144:118],
                                         // lines_per_block[171:145], block_pad[183:172],
                                         // status[185:184], zero[191:186]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [2:0] REG_UNIT_ORDER = 3'd0;
    localparam logic [2:0] REG_UNIT_BYTES = 3'd1;
    localparam logic [2:0] REG_SUBDUE     = 3'd2;
    localparam logic [2:0] REG_HEADER     = 3'd3;
    localparam logic [2:0] REG_BLOCK      = 3'd4;

    asc_pkg::t_cfg    r_cfg;
    asc_pkg::t_item   w_len_it;
    asc_pkg::t_item   w_cls_it;
    asc_pkg::t_item   w_prep_it;
    asc_pkg::t_item   w_div_it;
    asc_pkg::t_result w_res;
    logic             w_len_vld, w_len_rdy;
    logic             w_cls_vld, w_cls_rdy;
    logic             w_prep_vld, w_prep_rdy;
    logic             w_div_vld, w_div_rdy;
    logic             w_wr;

    // Register writes on the access phase
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uo <= 3'd0;
            r_cfg.ub <= 7'd1;
            r_cfg.sx <= 4'd3;
            r_cfg.hb <= 6'd32;
            r_cfg.bs <= 31'd1048576;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_UNIT_ORDER: r_cfg.uo <= pwdata[2:0];
                REG_UNIT_BYTES: r_cfg.ub <= pwdata[6:0];
                REG_SUBDUE:     r_cfg.sx <= pwdata[3:0];
                REG_HEADER:     r_cfg.hb <= pwdata[5:0];
                REG_BLOCK:      r_cfg.bs <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[4:2])
            REG_UNIT_ORDER: prdata = 32'(r_cfg.uo);
            REG_UNIT_BYTES: prdata = 32'(r_cfg.ub);
            REG_SUBDUE:     prdata = 32'(r_cfg.sx);
            REG_HEADER:     prdata = 32'(r_cfg.hb);
            REG_BLOCK:      prdata = 32'(r_cfg.bs);
            default:        prdata = '0;
        endcase
    end

    asc_len u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_op    (s_axis_tuser[0]),
        .i_size  (s_axis_tdata[31:0]),
        .i_idx   (s_axis_tdata[47:32]),
        .o_vld   (w_len_vld),
        .i_rdy   (w_len_rdy),
        .o_item  (w_len_it)
    );

    asc_cls u_cls (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (w_len_vld),
        .o_rdy   (w_len_rdy),
        .i_item  (w_len_it),
        .o_vld   (w_cls_vld),
        .i_rdy   (w_cls_rdy),
        .o_item  (w_cls_it)
    );

    asc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (w_cls_vld),
        .o_rdy   (w_cls_rdy),
        .i_item  (w_cls_it),
        .o_vld   (w_prep_vld),
        .i_rdy   (w_prep_rdy),
        .o_item  (w_prep_it)
    );

    asc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (w_prep_vld),
        .o_rdy   (w_prep_rdy),
        .i_item  (w_prep_it),
        .o_vld   (w_div_vld),
        .i_rdy   (w_div_rdy),
        .o_item  (w_div_it)
    );

    asc_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_div_vld),
        .o_rdy   (w_div_rdy),
        .i_item  (w_div_it),
        .o_vld   (m_axis_tvalid),
        .i_rdy   (m_axis_tready),
        .o_res   (w_res)
    );

    // Pack the result, first field lowest
    assign m_axis_tdata = {6'd0,
                           w_res.status,
                           w_res.block_pad,
                           w_res.lines_per_block,
                           w_res.block_chunks,
                           w_res.line_qwords,
                           w_res.line_pad,
                           w_res.line_chunks,
                           w_res.class_length,
                           w_res.class_out};

endmodule

// ----- sv/asc_chk.sv -----
// Port-level checks on the result channel of the size-class engine, bound to the top level.
`timescale 1ns / 1ps

module asc_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_m_tvalid,
    input logic         i_m_tready,
    input logic [191:0] i_m_tdata
);

    logic [1:0]  w_status;
    logic [26:0] w_lpb;
    logic [11:0] w_bpad;

    assign w_status = i_m_tdata[185:184];
    assign w_lpb    = i_m_tdata[171:145];
    assign w_bpad   = i_m_tdata[183:172];

    // Nothing delivered straight after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed");

    // No-fit status comes with zero lines per block
    a_nofit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (w_status == asc_pkg::ST_NOFIT) |-> (w_lpb == '0))
        else $error("no-fit status with lines per block");

    // Padding failure needs lines and a non-zero block pad
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (w_status == asc_pkg::ST_PAD) |-> (w_lpb != '0) && (w_bpad != '0))
        else $error("padding status without lines or pad");

endmodule

bind alloc_size_class_shape_top asc_chk u_asc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
